// ===== design/arqe_pkg.sv =====
package arqe_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    CMD_FRAME = 2'd0,
    CMD_SEND  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    FT_DATA  = 2'd0,
    FT_ACK   = 2'd1,
    FT_CLOSE = 2'd2,
    FT_OTHER = 2'd3
  } frame_type_t;

  typedef enum logic [1:0] {
    MODE_FREE      = 2'd0,
    MODE_CONNECTED = 2'd1,
    MODE_CLOSED    = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_RETX  = 2'd3
  } send_kind_t;

  localparam logic [CFG_IDX_W-1:0] CFG_CONN_ID       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;

  localparam logic [7:0]  CONN_ID_RST       = 8'd0;
  localparam logic [7:0]  MAX_RETRIES_RST   = 8'd10;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;
  localparam logic [8:0]  RETRY_SAT         = 9'd511;

  typedef struct packed {
    logic        tx_is_eof;
    logic        rx_space_ok;
    logic [7:0]  frame_conn;
    logic        frame_seq;
    frame_type_t frame_type;
    cmd_t        cmd;
  } item_t;

  typedef struct packed {
    logic       awaiting_ack;
    mode_t      link_state;
    logic       link_failed;
    logic       remote_closed;
    logic       tx_accepted;
    logic       out_seq;
    send_kind_t send_kind;
    logic       deliver_payload;
    logic       ack_bit;
    logic       send_ack;
  } result_t;

  typedef struct packed {
    logic [7:0]  conn_id;
    logic [7:0]  max_retries;
    logic [15:0] timeout_ticks;
  } cfg_t;

endpackage

// ===== design/arqe_in_stage.sv =====
module arqe_in_stage (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [arqe_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic [arqe_pkg::IN_USER_W-1:0]      in_tuser,
  input  logic                                fire,
  output logic                                item_valid,
  output arqe_pkg::item_t                     item
);

  logic            valid_r, valid_nxt;
  arqe_pkg::item_t item_r, item_nxt;

  assign in_tready = !valid_r || fire;

  always_comb begin
    item_nxt.cmd         = arqe_pkg::cmd_t'(in_tuser[1:0]);
    item_nxt.frame_type  = arqe_pkg::frame_type_t'(in_tdata[1:0]);
    item_nxt.frame_seq   = in_tdata[2];
    item_nxt.frame_conn  = in_tdata[10:3];
    item_nxt.rx_space_ok = in_tdata[11];
    item_nxt.tx_is_eof   = in_tdata[12];
    valid_nxt = in_tvalid || (valid_r && !fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== design/arqe_cfg_regs.sv =====
module arqe_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [arqe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [arqe_pkg::CFG_DATA_W-1:0]  cfg_data,
  output arqe_pkg::cfg_t                   cfg
);

  arqe_pkg::cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        arqe_pkg::CFG_CONN_ID:       cfg_nxt.conn_id       = cfg_data[7:0];
        arqe_pkg::CFG_MAX_RETRIES:   cfg_nxt.max_retries   = cfg_data[7:0];
        arqe_pkg::CFG_TIMEOUT_TICKS: cfg_nxt.timeout_ticks = cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.conn_id       <= arqe_pkg::CONN_ID_RST;
      cfg_r.max_retries   <= arqe_pkg::MAX_RETRIES_RST;
      cfg_r.timeout_ticks <= arqe_pkg::TIMEOUT_TICKS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/arqe_core.sv =====
module arqe_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  arqe_pkg::item_t   item,
  input  arqe_pkg::cfg_t    cfg,
  output arqe_pkg::result_t res
);

  arqe_pkg::mode_t mode_r, mode_nxt;
  logic            rx_exp_r, rx_exp_nxt;
  logic            tx_last_r, tx_last_nxt;
  logic            waiting_r, waiting_nxt;
  logic [8:0]      retry_r, retry_nxt;
  logic [15:0]     ticks_r, ticks_nxt;

  logic        is_frame, close_hit, close_new, ack_hit, data_ack, data_new;
  logic        tx_ok, tick_on, timeout, fail, retx;
  logic [15:0] ticks_dec;
  logic [8:0]  retry_inc;

  // event decode
  always_comb begin
    is_frame  = (item.cmd == arqe_pkg::CMD_FRAME) && (item.frame_conn == cfg.conn_id);
    close_hit = is_frame && (item.frame_type == arqe_pkg::FT_CLOSE);
    close_new = close_hit && (item.frame_seq == rx_exp_r);
    ack_hit   = is_frame && (item.frame_type == arqe_pkg::FT_ACK) &&
                (mode_r != arqe_pkg::MODE_FREE) && waiting_r && (tx_last_r == item.frame_seq);
    data_ack  = is_frame && (item.frame_type == arqe_pkg::FT_DATA) &&
                (mode_r == arqe_pkg::MODE_CONNECTED) && item.rx_space_ok;
    data_new  = data_ack && (item.frame_seq == rx_exp_r);
    tx_ok     = (item.cmd == arqe_pkg::CMD_SEND) && (mode_r == arqe_pkg::MODE_CONNECTED) &&
                !waiting_r;
    tick_on   = (item.cmd == arqe_pkg::CMD_TICK) && (mode_r != arqe_pkg::MODE_FREE) &&
                waiting_r;
    ticks_dec = (ticks_r == 16'd0) ? 16'd0 : ticks_r - 16'd1;
    retry_inc = (retry_r == arqe_pkg::RETRY_SAT) ? retry_r : retry_r + 9'd1;
    timeout   = tick_on && (ticks_dec == 16'd0);
    fail      = timeout && (retry_inc > {1'b0, cfg.max_retries});
    retx      = timeout && !fail;
  end

  // next state
  always_comb begin
    mode_nxt    = mode_r;
    rx_exp_nxt  = rx_exp_r;
    tx_last_nxt = tx_last_r;
    waiting_nxt = waiting_r;
    retry_nxt   = retry_r;
    ticks_nxt   = ticks_r;
    if (close_new) begin
      rx_exp_nxt = !rx_exp_r;
      mode_nxt   = arqe_pkg::MODE_CLOSED;
    end
    if (data_new) begin
      rx_exp_nxt = !rx_exp_r;
    end
    if (ack_hit) begin
      waiting_nxt = 1'b0;
      if (mode_r == arqe_pkg::MODE_CLOSED) begin
        mode_nxt = arqe_pkg::MODE_FREE;
      end
    end
    if (tx_ok) begin
      tx_last_nxt = !tx_last_r;
      waiting_nxt = 1'b1;
      ticks_nxt   = cfg.timeout_ticks;
      retry_nxt   = 9'd0;
      if (item.tx_is_eof) begin
        mode_nxt = arqe_pkg::MODE_CLOSED;
      end
    end
    if (tick_on) begin
      ticks_nxt = ticks_dec;
      if (timeout) begin
        retry_nxt = retry_inc;
      end
      if (fail) begin
        mode_nxt    = arqe_pkg::MODE_FREE;
        waiting_nxt = 1'b0;
      end
      if (retx) begin
        ticks_nxt = cfg.timeout_ticks;
      end
    end
  end

  // result fields
  always_comb begin
    res.send_ack        = close_hit || data_ack;
    res.ack_bit         = (close_hit || data_ack) && item.frame_seq;
    res.deliver_payload = data_new;
    res.tx_accepted     = tx_ok;
    res.remote_closed   = close_new;
    res.link_failed     = fail;
    res.link_state      = mode_nxt;
    res.awaiting_ack    = waiting_nxt;
    if (tx_ok) begin
      res.send_kind = item.tx_is_eof ? arqe_pkg::KIND_CLOSE : arqe_pkg::KIND_DATA;
      res.out_seq   = !tx_last_r;
    end else if (retx) begin
      res.send_kind = arqe_pkg::KIND_RETX;
      res.out_seq   = tx_last_r;
    end else begin
      res.send_kind = arqe_pkg::KIND_NONE;
      res.out_seq   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= arqe_pkg::MODE_CONNECTED;
      rx_exp_r  <= 1'b1;
      tx_last_r <= 1'b0;
      waiting_r <= 1'b0;
      retry_r   <= 9'd0;
      ticks_r   <= 16'd0;
    end else if (fire) begin
      mode_r    <= mode_nxt;
      rx_exp_r  <= rx_exp_nxt;
      tx_last_r <= tx_last_nxt;
      waiting_r <= waiting_nxt;
      retry_r   <= retry_nxt;
      ticks_r   <= ticks_nxt;
    end
  end

  a_fail_frees: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.link_failed |=> mode_r == arqe_pkg::MODE_FREE && !waiting_r)
    else $error("link failure did not free the link");

  a_tx_arms_timer: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.tx_accepted |=> waiting_r && ticks_r == $past(cfg.timeout_ticks) &&
    retry_r == 9'd0)
    else $error("accepted send did not arm the retransmit timer");

  a_retx_seq: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.send_kind == arqe_pkg::KIND_RETX |-> res.out_seq == tx_last_r && waiting_r)
    else $error("retransmit carries wrong sequence bit");

  a_deliver_toggles: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (res.deliver_payload || res.remote_closed) |=> rx_exp_r != $past(rx_exp_r))
    else $error("in-order frame did not advance expected bit");

endmodule

// ===== design/arqe_out_stage.sv =====
module arqe_out_stage (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              fire,
  input  arqe_pkg::result_t                 res,
  output logic                              can_load,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [arqe_pkg::OUT_DATA_W-1:0]   out_tdata
);

  logic              valid_r, valid_nxt;
  arqe_pkg::result_t res_r;

  assign can_load  = !valid_r || out_tready;
  assign valid_nxt = fire || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{(arqe_pkg::OUT_DATA_W - $bits(arqe_pkg::result_t)){1'b0}}, res_r};

endmodule

// ===== design/stop_and_wait_arq_endpoint_unit.sv =====
// alternating-bit stop-and-wait endpoint, control decisions only
// in channel: one event per transfer; in_tuser is the command (frame header,
//   send request, timer tick), in_tdata carries the frame header fields and
//   the queue and end-of-stream flags
// out channel: exactly one result transfer per input transfer, in order,
//   holding ack, delivery, send and link status flags after the event
// cfg channel: register index and data, always ready; write only while idle
// latency: an accepted event is registered, evaluated in the next cycle and
//   its result shows on out_tvalid one cycle after that, two cycles in all
// throughput: one event per cycle; the endpoint state update is a single
//   cycle of flag and counter logic between the input and output registers
// stall: while out_tready is low the result holds, the input register fills
//   and then in_tready drops; no event is lost or repeated
// reset: synchronous active-low; link connected, expected bit 1, last sent
//   bit 0, no wait pending, config back to defaults
module stop_and_wait_arq_endpoint_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // frame_type[1:0], frame_seq[2], frame_conn[10:3], rx_space_ok[11], tx_is_eof[12]
  input  logic [arqe_pkg::IN_DATA_W-1:0]    in_tdata,
  // cmd[1:0]
  input  logic [arqe_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // send_ack[0], ack_bit[1], deliver_payload[2], send_kind[4:3], out_seq[5],
  // tx_accepted[6], remote_closed[7], link_failed[8], link_state[10:9], awaiting_ack[11]
  output logic [arqe_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [arqe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [arqe_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic              item_valid, can_load, fire;
  arqe_pkg::item_t   item;
  arqe_pkg::cfg_t    cfg;
  arqe_pkg::result_t res;

  assign fire = item_valid && can_load;

  arqe_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .fire       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  arqe_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  arqe_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .cfg   (cfg),
    .res   (res)
  );

  arqe_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .res        (res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== sim/stop_and_wait_arq_endpoint_unit_tb.sv =====
`timescale 1ns / 1ps

module stop_and_wait_arq_endpoint_unit_tb;

  localparam int unsigned CYCLE_LIMIT = 400000;

  class arq_scoreboard;
    logic [7:0]        conn_id;
    logic [7:0]        max_retries;
    logic [15:0]       timeout_ticks;
    arqe_pkg::mode_t   mode;
    bit                rx_exp;
    bit                tx_last;
    bit                waiting;
    bit [8:0]          retries;
    bit [15:0]         ticks_left;
    arqe_pkg::result_t expected_q[$];
    int unsigned       mismatches;

    function new();
      conn_id       = arqe_pkg::CONN_ID_RST;
      max_retries   = arqe_pkg::MAX_RETRIES_RST;
      timeout_ticks = arqe_pkg::TIMEOUT_TICKS_RST;
      mode          = arqe_pkg::MODE_CONNECTED;
      rx_exp        = 1'b1;
      tx_last       = 1'b0;
      waiting       = 1'b0;
      retries       = '0;
      ticks_left    = '0;
      mismatches    = 0;
    endfunction

    function void write_reg(logic [arqe_pkg::CFG_IDX_W-1:0] idx,
                            logic [arqe_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        arqe_pkg::CFG_CONN_ID:       conn_id = val[7:0];
        arqe_pkg::CFG_MAX_RETRIES:   max_retries = val[7:0];
        arqe_pkg::CFG_TIMEOUT_TICKS: timeout_ticks = val;
        default: ;
      endcase
    endfunction

    // a tick now would push the retry count past the limit
    function bit tick_fails();
      bit [8:0] next_retries;
      next_retries = (retries < arqe_pkg::RETRY_SAT) ? retries + 9'd1 : retries;
      return mode != arqe_pkg::MODE_FREE && waiting && ticks_left <= 16'd1 &&
             next_retries > {1'b0, max_retries};
    endfunction

    function arqe_pkg::result_t endpoint_step(arqe_pkg::item_t it);
      arqe_pkg::result_t r;
      r = '0;
      case (it.cmd)
        arqe_pkg::CMD_FRAME: begin
          if (it.frame_conn == conn_id) begin
            case (it.frame_type)
              arqe_pkg::FT_CLOSE: begin
                r.send_ack = 1'b1;
                r.ack_bit  = it.frame_seq;
                if (it.frame_seq == rx_exp) begin
                  rx_exp = ~rx_exp;
                  mode = arqe_pkg::MODE_CLOSED;
                  r.remote_closed = 1'b1;
                end
              end
              arqe_pkg::FT_ACK: begin
                if (mode != arqe_pkg::MODE_FREE && waiting && tx_last == it.frame_seq) begin
                  waiting = 1'b0;
                  if (mode == arqe_pkg::MODE_CLOSED) mode = arqe_pkg::MODE_FREE;
                end
              end
              arqe_pkg::FT_DATA: begin
                if (mode == arqe_pkg::MODE_CONNECTED && it.rx_space_ok) begin
                  r.send_ack = 1'b1;
                  r.ack_bit  = it.frame_seq;
                  if (it.frame_seq == rx_exp) begin
                    rx_exp = ~rx_exp;
                    r.deliver_payload = 1'b1;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        arqe_pkg::CMD_SEND: begin
          if (mode == arqe_pkg::MODE_CONNECTED && !waiting) begin
            r.tx_accepted = 1'b1;
            tx_last = ~tx_last;
            r.out_seq = tx_last;
            if (it.tx_is_eof) begin
              mode = arqe_pkg::MODE_CLOSED;
              r.send_kind = arqe_pkg::KIND_CLOSE;
            end else begin
              r.send_kind = arqe_pkg::KIND_DATA;
            end
            waiting    = 1'b1;
            ticks_left = timeout_ticks;
            retries    = '0;
          end
        end
        arqe_pkg::CMD_TICK: begin
          if (mode != arqe_pkg::MODE_FREE && waiting) begin
            if (ticks_left > 0) ticks_left--;
            if (ticks_left == 0) begin
              if (retries < arqe_pkg::RETRY_SAT) retries++;
              if (retries > {1'b0, max_retries}) begin
                r.link_failed = 1'b1;
                mode = arqe_pkg::MODE_FREE;
                waiting = 1'b0;
              end else begin
                r.send_kind = arqe_pkg::KIND_RETX;
                r.out_seq = tx_last;
                ticks_left = timeout_ticks;
              end
            end
          end
        end
        default: ;
      endcase
      r.link_state   = mode;
      r.awaiting_ack = waiting;
      return r;
    endfunction

    function void note_input(arqe_pkg::item_t it);
      expected_q.push_back(endpoint_step(it));
    endfunction

    function void check_result(logic [arqe_pkg::OUT_DATA_W-1:0] tdata);
      arqe_pkg::result_t got;
      arqe_pkg::result_t want;
      got = arqe_pkg::result_t'(tdata[11:0]);
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %h", tdata);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want || tdata[15:12] !== 4'b0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch at %0t (expected / actual):", $realtime);
          $display("  ack %b/%b ack_bit %b/%b deliver %b/%b kind %0d/%0d seq %b/%b",
                   want.send_ack, got.send_ack, want.ack_bit, got.ack_bit,
                   want.deliver_payload, got.deliver_payload,
                   want.send_kind, got.send_kind, want.out_seq, got.out_seq);
          $display("  accepted %b/%b rclosed %b/%b failed %b/%b state %0d/%0d wait %b/%b pad %h",
                   want.tx_accepted, got.tx_accepted, want.remote_closed, got.remote_closed,
                   want.link_failed, got.link_failed, want.link_state, got.link_state,
                   want.awaiting_ack, got.awaiting_ack, tdata[15:12]);
        end
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [arqe_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [arqe_pkg::IN_USER_W-1:0]  in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [arqe_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [arqe_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [arqe_pkg::CFG_DATA_W-1:0] cfg_data;

  arq_scoreboard   sb = new();
  arqe_pkg::item_t seen_item;
  int unsigned     cycles = 0;
  bit              in_idle_on = 1'b1;
  bit              out_idle_on = 1'b1;
  bit              long_hold_req = 1'b0;

  stop_and_wait_arq_endpoint_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // every transfer is seen here, input before output
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) begin
        seen_item.cmd         = arqe_pkg::cmd_t'(in_tuser);
        seen_item.frame_type  = arqe_pkg::frame_type_t'(in_tdata[1:0]);
        seen_item.frame_seq   = in_tdata[2];
        seen_item.frame_conn  = in_tdata[10:3];
        seen_item.rx_space_ok = in_tdata[11];
        seen_item.tx_is_eof   = in_tdata[12];
        sb.note_input(seen_item);
      end
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  // result side back-pressure
  initial begin
    int unsigned stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 39) == 0) out_idle_on = !out_idle_on;
      stall = out_idle_on ? $urandom_range(0, 8) : 0;
      if (long_hold_req) begin
        stall = 300;
        long_hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  function automatic arqe_pkg::item_t ev(arqe_pkg::cmd_t c, arqe_pkg::frame_type_t ft,
                                         bit seq, logic [7:0] conn, bit space, bit eof);
    arqe_pkg::item_t it;
    it.cmd         = c;
    it.frame_type  = ft;
    it.frame_seq   = seq;
    it.frame_conn  = conn;
    it.rx_space_ok = space;
    it.tx_is_eof   = eof;
    return it;
  endfunction

  // no in-order close, no accepted end of stream, no retry overflow
  function automatic arqe_pkg::item_t keep_link_open(arqe_pkg::item_t it);
    if (it.cmd == arqe_pkg::CMD_FRAME && it.frame_type == arqe_pkg::FT_CLOSE &&
        it.frame_conn == sb.conn_id && it.frame_seq == sb.rx_exp) begin
      it.frame_seq = ~it.frame_seq;
    end else if (it.cmd == arqe_pkg::CMD_SEND && sb.mode == arqe_pkg::MODE_CONNECTED &&
                 !sb.waiting) begin
      it.tx_is_eof = 1'b0;
    end else if (it.cmd == arqe_pkg::CMD_TICK && sb.tick_fails()) begin
      it = ev(arqe_pkg::CMD_FRAME, arqe_pkg::FT_ACK, sb.tx_last, sb.conn_id,
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    return it;
  endfunction

  function automatic arqe_pkg::item_t gen_event(bit allow_end);
    arqe_pkg::item_t it;
    int unsigned     pick;
    it.cmd         = arqe_pkg::CMD_FRAME;
    it.frame_type  = arqe_pkg::frame_type_t'($urandom_range(0, 3));
    it.frame_seq   = 1'($urandom_range(0, 1));
    it.frame_conn  = ($urandom_range(0, 9) != 0) ? sb.conn_id : 8'($urandom);
    it.rx_space_ok = ($urandom_range(0, 7) != 0);
    it.tx_is_eof   = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      it.frame_type = arqe_pkg::FT_DATA;
      if ($urandom_range(0, 3) != 0) it.frame_seq = sb.rx_exp;
    end else if (pick < 45) begin
      it.frame_type = arqe_pkg::FT_ACK;
      if (sb.waiting && $urandom_range(0, 4) != 0) it.frame_seq = sb.tx_last;
    end else if (pick < 60) begin
      it.cmd = arqe_pkg::CMD_SEND;
      if (allow_end) it.tx_is_eof = ($urandom_range(0, 7) == 0);
    end else if (pick < 85) begin
      it.cmd = arqe_pkg::CMD_TICK;
    end else if (pick < 92) begin
      it.frame_type = arqe_pkg::FT_CLOSE;
    end else if (pick < 96) begin
      it.frame_type = arqe_pkg::FT_OTHER;
    end else if (pick < 98) begin
      it.cmd = arqe_pkg::CMD_NOP;
    end else begin
      it.cmd = arqe_pkg::cmd_t'($urandom_range(0, 3));
      it.frame_conn = 8'($urandom);
    end
    if (!allow_end) it = keep_link_open(it);
    return it;
  endfunction

  // called at a falling edge, returns at the accepting rising edge
  task automatic send_event(arqe_pkg::item_t it);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) in_idle_on = !in_idle_on;
    gap = in_idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.cmd;
    in_tdata  <= {3'b0, it.tx_is_eof, it.rx_space_ok, it.frame_conn, it.frame_seq,
                  it.frame_type};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic post(arqe_pkg::cmd_t c, arqe_pkg::frame_type_t ft, bit seq,
                      logic [7:0] conn, bit space, bit eof);
    @(negedge clk);
    send_event(ev(c, ft, seq, conn, space, eof));
  endtask

  task automatic cfg_write(logic [arqe_pkg::CFG_IDX_W-1:0] idx,
                           logic [arqe_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(logic [7:0] conn, logic [7:0] retry_lim, logic [15:0] tmo,
                           int unsigned count, bit allow_end, int hold_at, int pause_at);
    wait_drained();
    cfg_write(arqe_pkg::CFG_CONN_ID, {8'($urandom), conn});
    cfg_write(arqe_pkg::CFG_MAX_RETRIES, {8'($urandom), retry_lim});
    cfg_write(arqe_pkg::CFG_TIMEOUT_TICKS, tmo);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) long_hold_req = 1'b1;
      if (i == pause_at) wait_drained();
      @(negedge clk);
      send_event(gen_event(allow_end));
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = arqe_pkg::CMD_NOP;
    cfg_valid = 1'b0;
    cfg_index = arqe_pkg::CFG_CONN_ID;
    cfg_data  = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset settings: conn 0, 10 retries, 1000 ticks
    post(arqe_pkg::CMD_NOP,   arqe_pkg::FT_OTHER, 1'b1, 8'hFF, 1'b1, 1'b1);
    post(arqe_pkg::CMD_FRAME, arqe_pkg::FT_DATA,  1'b1, 8'h00, 1'b1, 1'b0);
    post(arqe_pkg::CMD_FRAME, arqe_pkg::FT_DATA,  1'b1, 8'h00, 1'b1, 1'b0);
    post(arqe_pkg::CMD_FRAME, arqe_pkg::FT_DATA,  1'b0, 8'h00, 1'b0, 1'b0);
    post(arqe_pkg::CMD_FRAME, arqe_pkg::FT_DATA,  1'b0, 8'hFF, 1'b1, 1'b0);
    post(arqe_pkg::CMD_FRAME, arqe_pkg::FT_OTHER, 1'b0, 8'h00, 1'b1, 1'b1);
    post(arqe_pkg::CMD_FRAME, arqe_pkg::FT_ACK,   1'b1, 8'h00, 1'b1, 1'b0);
    post(arqe_pkg::CMD_SEND,  arqe_pkg::FT_DATA,  1'b0, 8'h00, 1'b0, 1'b0);
    post(arqe_pkg::CMD_SEND,  arqe_pkg::FT_DATA,  1'b0, 8'h00, 1'b0, 1'b1);
    post(arqe_pkg::CMD_FRAME, arqe_pkg::FT_ACK,   1'b0, 8'h00, 1'b1, 1'b0);
    post(arqe_pkg::CMD_FRAME, arqe_pkg::FT_ACK,   1'b1, 8'hFF, 1'b1, 1'b0);
    post(arqe_pkg::CMD_TICK,  arqe_pkg::FT_DATA,  1'b0, 8'h00, 1'b0, 1'b0);
    post(arqe_pkg::CMD_TICK,  arqe_pkg::FT_CLOSE, 1'b1, 8'hFF, 1'b1, 1'b1);
    post(arqe_pkg::CMD_FRAME, arqe_pkg::FT_ACK,   1'b1, 8'h00, 1'b1, 1'b0);
    post(arqe_pkg::CMD_FRAME, arqe_pkg::FT_CLOSE, 1'b1, 8'h00, 1'b1, 1'b0);
    post(arqe_pkg::CMD_FRAME, arqe_pkg::FT_CLOSE, 1'b0, 8'hFF, 1'b1, 1'b0);
    post(arqe_pkg::CMD_TICK,  arqe_pkg::FT_DATA,  1'b0, 8'h00, 1'b1, 1'b0);
    post(arqe_pkg::CMD_FRAME, arqe_pkg::FT_DATA,  1'b0, 8'h00, 1'b1, 1'b0);
    post(arqe_pkg::CMD_SEND,  arqe_pkg::FT_DATA,  1'b1, 8'h5A, 1'b1, 1'b0);
    post(arqe_pkg::CMD_FRAME, arqe_pkg::FT_ACK,   1'b0, 8'h00, 1'b1, 1'b0);

    run_phase(8'h5A, 8'd3,   16'd2,     230, 1'b0, 50, -1);
    run_phase(8'hFF, 8'd0,   16'd1,     230, 1'b0, -1, 110);
    run_phase(8'h00, 8'd255, 16'd0,     230, 1'b0, -1, -1);
    run_phase(8'hA5, 8'd1,   16'hFFFF,  230, 1'b0, 120, -1);
    run_phase(8'h01, 8'd2,   16'd3,     230, 1'b0, -1, -1);
    run_phase(8'h80, 8'd5,   16'd1,     230, 1'b0, -1, 60);
    run_phase(8'h3C, 8'd1,   16'd2,     320, 1'b1, -1, -1);

    // drive the link through close and release
    wait_drained();
    send_event(ev(arqe_pkg::CMD_FRAME, arqe_pkg::FT_CLOSE, sb.rx_exp, sb.conn_id, 1'b1, 1'b0));
    wait_drained();
    send_event(ev(arqe_pkg::CMD_FRAME, arqe_pkg::FT_DATA, sb.rx_exp, sb.conn_id, 1'b1, 1'b0));
    wait_drained();
    send_event(ev(arqe_pkg::CMD_SEND, arqe_pkg::FT_DATA, 1'b0, sb.conn_id, 1'b1, 1'b1));
    wait_drained();
    send_event(ev(arqe_pkg::CMD_TICK, arqe_pkg::FT_DATA, 1'b0, sb.conn_id, 1'b1, 1'b0));
    wait_drained();
    send_event(ev(arqe_pkg::CMD_FRAME, arqe_pkg::FT_ACK, sb.tx_last, sb.conn_id, 1'b1, 1'b0));
    wait_drained();
    send_event(ev(arqe_pkg::CMD_TICK, arqe_pkg::FT_DATA, 1'b0, sb.conn_id, 1'b1, 1'b0));
    wait_drained();
    send_event(ev(arqe_pkg::CMD_FRAME, arqe_pkg::FT_CLOSE, sb.rx_exp, sb.conn_id, 1'b1, 1'b0));

    wait_drained();
    repeat (6) @(negedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
